/* src/assert_macros.svh */
// Assertion macros for the top-level RTL file; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define MBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/mba_pkg.sv */
// Shared types and fixed constants of the boxcar averager.
package mba_pkg;

  localparam int CHAN_W = 6;   // channel field width
  localparam int WIN_W  = 6;   // window, slot, fill and count widths
  localparam int IN_W   = 16;  // sample field width
  localparam int OUT_W  = 16;  // mean field width

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_LAST,
    ST_START,
    ST_DIV,
    ST_DONE
  } mba_state_t;

endpackage

/* src/mba_hist_ram.sv */
// History store: one write port, one read port, registered read data.
module mba_hist_ram import mba_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/mba_div.sv */
// Restoring divider: W-bit magnitude by a window-wide count, one quotient bit a cycle.
module mba_div import mba_pkg::*; #(
  parameter int W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     dividend,
  input  logic [WIN_W-1:0] divisor,
  output logic             done,
  output logic [W-1:0]     quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]     q_r;
  logic [WIN_W-1:0] rem_r;
  logic [WIN_W-1:0] div_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIN_W:0]   rem_sh;
  logic [WIN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, q_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[W-2:0], ge};
      rem_r <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* src/multichannel_boxcar_average.sv */
// Top level of the multichannel boxcar averager: control, accumulator and result register.
// Usage:
//   Input channel (in_valid/in_ready): one sample request per channel reading,
//   with in_scan_start high on the first sample of each scan.
//   Result channel (out_valid/out_ready): at most one result per request,
//   carrying the channel, the mean of its first fill-count history entries
//   (truncated toward zero) and that count.
//   Config channel (cfg_valid/cfg_ready): writes the window length and clears
//   the shared slot and fill count; write it only while the block is idle.
// Operation: a request sums its fill entries, where fill is the number of
//   entries summed (one history read per cycle through the single read
//   port), then runs the bit-serial divider, whose width is SW = SAMPLE_BITS
//   + clog2(MAX_WINDOW) + 1. Requests are handled one at a time.
// Reset: a clearing pass zeroes all CHANNELS * MAX_WINDOW history entries
//   (2048 at defaults); in_ready stays low meanwhile, config writes
//   are still taken.
// Stall: a finished result waits in the output register; the next request is
//   accepted and worked on, and holds at its end until that register frees.
`include "assert_macros.svh"

module multichannel_boxcar_average import mba_pkg::*; #(
  parameter int CHANNELS    = 64,
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [WIN_W-1:0]        cfg_window_length,
  // input requests
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHAN_W-1:0]       in_chan,
  input  logic signed [IN_W-1:0]  in_sample,
  input  logic                    in_scan_start,
  // results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAN_W-1:0]       out_chan,
  output logic signed [OUT_W-1:0] out_mean_value,
  output logic [WIN_W-1:0]        out_samples_used
);

  localparam int DEPTH = CHANNELS * MAX_WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int EW    = (SW > OUT_W) ? SW : OUT_W;

  mba_state_t state_r, state_nxt;

  // configuration and shared scan state
  logic [WIN_W-1:0] window_r;
  logic [WIN_W-1:0] slot_r, slot_nxt;
  logic [WIN_W-1:0] fill_r, fill_nxt;

  // per-request working registers
  logic [AW-1:0]        clr_addr_r;
  logic [CHAN_W-1:0]    chan_r;
  logic [AW-1:0]        base_r;
  logic [WIN_W-1:0]     used_r;
  logic [WIN_W-1:0]     k_r;
  logic                 rvalid_r;
  logic signed [SW-1:0] acc_r;
  logic                 neg_r;

  // result register
  logic                    out_valid_r;
  logic [CHAN_W-1:0]       out_chan_r;
  logic signed [OUT_W-1:0] out_mean_r;
  logic [WIN_W-1:0]        out_used_r;

  // memory ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // divider
  logic          div_start;
  logic          div_done;
  logic [SW-1:0] div_dividend;
  logic [SW-1:0] div_quot;

  logic                   in_acc;
  logic                   cfg_acc;
  logic                   win_ok;
  logic                   chan_ok;
  logic                   advance;
  logic                   store;
  logic [AW-1:0]          in_base;
  logic [AW-1:0]          in_waddr;
  logic [SAMPLE_BITS-1:0] sample_st;
  logic                   out_load;
  logic signed [SW-1:0]   mean_s;
  logic signed [EW-1:0]   mean_ext;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  // Slot and fill update for the request at the port.
  assign win_ok  = (window_r != '0) && (32'(window_r) <= MAX_WINDOW);
  assign chan_ok = 32'(in_chan) < CHANNELS;
  assign advance = in_scan_start || (slot_r == '0);

  always_comb begin
    slot_nxt = slot_r;
    fill_nxt = fill_r;
    if (advance) begin
      if (slot_r >= window_r) begin
        slot_nxt = WIN_W'(1);
      end else begin
        slot_nxt = slot_r + 1'b1;
        if (fill_r != window_r) begin
          fill_nxt = slot_nxt;
        end
      end
    end
  end

  assign store    = win_ok && chan_ok && (fill_nxt != '0) && (slot_nxt != '0);
  assign in_base  = AW'(32'(in_chan) * MAX_WINDOW);
  assign in_waddr = in_base + AW'(slot_nxt) - AW'(1);

  // Narrow samples keep their sign; wide stores take the field as unsigned bits.
  generate
    if (SAMPLE_BITS <= IN_W) begin : g_narrow
      assign sample_st = in_sample[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign sample_st = {{(SAMPLE_BITS - IN_W){1'b0}}, in_sample};
    end
  endgenerate

  // Memory port muxing: clear sweep, then sample writes and summing reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_waddr;
    ram_wdata = sample_st;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (in_acc && store) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = (state_r == ST_SUM);
  assign ram_raddr = base_r + AW'(k_r);

  // Divider operands: magnitude in, sign restored on the way out.
  assign div_start    = (state_r == ST_START);
  assign div_dividend = acc_r[SW-1] ? SW'(-acc_r) : SW'(acc_r);
  assign mean_s       = neg_r ? -signed'(div_quot) : signed'(div_quot);
  assign mean_ext     = EW'(mean_s);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Control sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && store) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (k_r == used_r - 1'b1) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Window register, shared slot and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      slot_r   <= '0;
      fill_r   <= '0;
    end else if (cfg_acc) begin
      window_r <= cfg_window_length;
      slot_r   <= '0;
      fill_r   <= '0;
    end else if (in_acc && win_ok) begin
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Clear sweep address and read pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      k_r        <= '0;
      rvalid_r   <= 1'b0;
    end else begin
      rvalid_r <= (state_r == ST_SUM);
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (in_acc) begin
        k_r <= '0;
      end else if (state_r == ST_SUM) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // Request payload and running sum.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r <= in_chan;
      base_r <= in_base;
      used_r <= fill_nxt;
      acc_r  <= '0;
    end else if (rvalid_r) begin
      acc_r <= acc_r + SW'(signed'(ram_rdata));
    end
    if (div_start) begin
      neg_r <= acc_r[SW-1];
    end
  end

  // Result register: hold until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= chan_r;
      out_mean_r <= mean_ext[OUT_W-1:0];
      out_used_r <= used_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chan         = out_chan_r;
  assign out_mean_value   = out_mean_r;
  assign out_samples_used = out_used_r;

  mba_hist_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_BITS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mba_div #(
    .W (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (used_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Slot and fill never pass the window.
  `MBA_ASSERT_IMP(a_slot_fill_in_window, 1'b1, (slot_r <= window_r) && (fill_r <= window_r))
  // Summing reads stay within the entries in use.
  `MBA_ASSERT_IMP(a_read_in_range, state_r == ST_SUM, k_r < used_r)
  // The divider finishes only while the sequencer waits for it.
  `MBA_ASSERT_IMP(a_div_done_in_div, div_done, state_r == ST_DIV)
  // A result waiting on a stalled receiver is not overwritten.
  `MBA_ASSERT_NXT(a_result_held, out_valid_r && !out_ready, out_valid_r && $stable(out_mean_r))

endmodule
